[rtl/core/stop_and_wait_arq_sender_defines.svh]
// Assertion shorthands for the sender RTL.
`ifndef STOP_AND_WAIT_ARQ_SENDER_DEFINES_SVH
`define STOP_AND_WAIT_ARQ_SENDER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SWARQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SWARQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swarq_pkg.sv]
`default_nettype none

package swarq_pkg;

  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned BLK_W   = 16;
  localparam int unsigned TMO_W   = 20;
  localparam int unsigned ELAP_W  = 24;
  localparam int unsigned SEND_W  = 8;
  localparam int unsigned RETRY_W = 2;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINAL = 2'd2;

  localparam logic [STAT_W-1:0] STAT_IDLE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BUSY   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FAILED = 2'd3;

  localparam logic REG_BLOCK_COUNT  = 1'b0;
  localparam logic REG_INIT_TIMEOUT = 1'b1;

  localparam logic [TMO_W-1:0]   TMO_MAX     = 20'hFFFFF;
  localparam logic [TMO_W-1:0]   TMO_RESET   = 20'd1000;
  localparam logic [RETRY_W-1:0] RETRY_RESET = 2'd3;
  localparam logic [SEND_W-1:0]  SEND_MAX    = 8'd255;

  // reciprocals: ceil(2^k / d)
  localparam logic [31:0] RECIP5_34  = 32'd3435973837;
  localparam logic [23:0] RECIP5_26  = 24'd13421773;
  localparam logic [23:0] RECIP10_27 = 24'd13421773;
  localparam logic signed [31:0] DIV10_LO = 32'sd10;
  localparam logic signed [31:0] DIV10_HI = 32'sd10485760;

  typedef struct packed {
    logic capture;
    logic mul;
    logic scale;
    logic div;
    logic sub;
    logic add;
    logic mac;
    logic norm;
    logic apply;
    logic wcalc;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic adapt_req;
    logic out_free;
  } sts_t;

  // floor(6*t/5), unsaturated
  function automatic logic [TMO_W:0] six_fifths(input logic [TMO_W-1:0] t);
    logic [22:0] six;
    logic [46:0] prod;
    six  = 23'({t, 2'b00}) + 23'({t, 1'b0});
    prod = 47'(six) * 47'(RECIP5_26);
    return prod[46:26];
  endfunction

endpackage

`default_nettype wire

[rtl/core/swarq_regs.sv]
`default_nettype none

module swarq_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swarq_pkg::ADDR_W-1:0]  paddr,
  input  logic [swarq_pkg::DATA_W-1:0]  pwdata,
  output logic [swarq_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [swarq_pkg::BLK_W-1:0]   block_count,
  output logic [swarq_pkg::TMO_W-1:0]   init_timeout
);

  logic [swarq_pkg::BLK_W-1:0] block_count_r, block_count_nxt;
  logic [swarq_pkg::TMO_W-1:0] init_tmo_r, init_tmo_nxt;
  logic                        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    block_count_nxt = block_count_r;
    init_tmo_nxt    = init_tmo_r;
    if (wr) begin
      case (paddr[2])
        swarq_pkg::REG_BLOCK_COUNT:  block_count_nxt = pwdata[swarq_pkg::BLK_W-1:0];
        swarq_pkg::REG_INIT_TIMEOUT: init_tmo_nxt    = pwdata[swarq_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      swarq_pkg::REG_BLOCK_COUNT:  prdata = 32'(block_count_r);
      swarq_pkg::REG_INIT_TIMEOUT: prdata = 32'(init_tmo_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= '0;
      init_tmo_r    <= swarq_pkg::TMO_RESET;
    end else begin
      block_count_r <= block_count_nxt;
      init_tmo_r    <= init_tmo_nxt;
    end
  end

  assign block_count  = block_count_r;
  assign init_timeout = init_tmo_r;

endmodule

`default_nettype wire

[rtl/core/swarq_ctrl.sv]
`default_nettype none

module swarq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  swarq_pkg::sts_t   sts,
  output swarq_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_DECIDE = 12'b0000_0000_0010,
    ST_MUL    = 12'b0000_0000_0100,
    ST_SCALE  = 12'b0000_0000_1000,
    ST_DIV    = 12'b0000_0001_0000,
    ST_SUB    = 12'b0000_0010_0000,
    ST_ADD    = 12'b0000_0100_0000,
    ST_MAC    = 12'b0000_1000_0000,
    ST_NORM   = 12'b0001_0000_0000,
    ST_APPLY  = 12'b0010_0000_0000,
    ST_WCALC  = 12'b0100_0000_0000,
    ST_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = sts.adapt_req ? ST_MUL : ST_APPLY;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac   = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_WCALC;
      end
      ST_WCALC: begin
        cmd.wcalc = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/swarq_dp.sv]
`default_nettype none

module swarq_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swarq_pkg::cmd_t               cmd,
  output swarq_pkg::sts_t               sts,
  input  logic [swarq_pkg::FUNC_W-1:0]  in_func,
  input  logic                          in_ack_bit,
  input  logic [swarq_pkg::ELAP_W-1:0]  in_elapsed_us,
  input  logic [swarq_pkg::BLK_W-1:0]   block_count,
  input  logic [swarq_pkg::TMO_W-1:0]   init_timeout,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [swarq_pkg::KIND_W-1:0]  out_send_kind,
  output logic                          out_seq_bit,
  output logic [swarq_pkg::TMO_W-1:0]   out_timer_load_us,
  output logic [swarq_pkg::STAT_W-1:0]  out_status,
  output logic [swarq_pkg::TMO_W-1:0]   out_timeout_now_us
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_FINAL = 4'b0100,
    PH_ENDED = 4'b1000
  } phase_t;

  // captured item
  logic [swarq_pkg::FUNC_W-1:0]  func_r;
  logic                          ack_r;
  logic [swarq_pkg::ELAP_W-1:0]  elap_r;

  // protocol state
  phase_t                         phase_r, phase_nxt;
  logic                           failed_r, failed_nxt;
  logic [swarq_pkg::BLK_W-1:0]    acked_r, acked_nxt;
  logic [swarq_pkg::SEND_W-1:0]   sends_r, sends_nxt;
  logic [swarq_pkg::RETRY_W-1:0]  retries_r, retries_nxt;
  logic [swarq_pkg::TMO_W-1:0]    rtt_r, rtt_nxt;
  logic [swarq_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic                           seq_r, seq_nxt;
  logic [swarq_pkg::TMO_W-1:0]    w_r;

  // timeout update stages
  logic [27:0]        rt_r;
  logic [30:0]        x_r;
  logic [26:0]        e5_r;
  logic [28:0]        qf_r;
  logic [20:0]        wold_r;
  logic signed [31:0] m_r;
  logic signed [31:0] m2_r;
  logic signed [31:0] v_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [swarq_pkg::KIND_W-1:0]  out_kind_r;
  logic                          out_seq_r;
  logic [swarq_pkg::TMO_W-1:0]   out_load_r;
  logic [swarq_pkg::STAT_W-1:0]  out_stat_r;
  logic [swarq_pkg::TMO_W-1:0]   out_tmo_r;

  logic                          matched;
  logic [swarq_pkg::SEND_W-1:0]  resends;
  logic [swarq_pkg::SEND_W-1:0]  sends_inc;
  logic [swarq_pkg::BLK_W-1:0]   acked_inc;
  logic [swarq_pkg::TMO_W-1:0]   init_clamped;
  logic [62:0]                   qf_prod;
  logic [30:0]                   qf_x5;
  logic                          round_up;
  logic signed [31:0]            half_t;
  logic [31:0]                   seven_t;
  logic [47:0]                   q_prod;
  logic [swarq_pkg::TMO_W-1:0]   rtt_adapt;
  logic [20:0]                   w_full;
  logic [swarq_pkg::STAT_W-1:0]  stat;

  assign matched   = (ack_r == acked_r[0]);
  assign resends   = (sends_r != '0) ? sends_r - 8'd1 : '0;
  assign sends_inc = (sends_r == swarq_pkg::SEND_MAX) ? sends_r : sends_r + 8'd1;
  assign acked_inc = acked_r + 16'd1;
  assign init_clamped = (init_timeout == '0) ? 20'd1 : init_timeout;

  assign sts.adapt_req = (func_r == swarq_pkg::FUNC_ACK) && (phase_r == PH_DATA) && matched;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // arithmetic of the timeout update
  assign qf_prod  = 63'(x_r) * 63'(swarq_pkg::RECIP5_34);
  assign qf_x5    = 31'({qf_r, 2'b00}) + 31'(qf_r);
  assign round_up = ({4'b0, e5_r} >= x_r) && (qf_x5 != x_r);
  assign half_t   = $signed({13'b0, rtt_r[swarq_pkg::TMO_W-1:1]});
  assign seven_t  = 32'({rtt_r, 3'b000}) - 32'(rtt_r);
  assign q_prod   = 48'(v_r[23:0]) * 48'(swarq_pkg::RECIP10_27);
  assign w_full   = swarq_pkg::six_fifths(rtt_r);

  always_comb begin
    if (v_r < swarq_pkg::DIV10_LO) begin
      rtt_adapt = 20'd1;
    end else if (v_r >= swarq_pkg::DIV10_HI) begin
      rtt_adapt = swarq_pkg::TMO_MAX;
    end else begin
      rtt_adapt = q_prod[46:27];
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    failed_nxt  = failed_r;
    acked_nxt   = acked_r;
    sends_nxt   = sends_r;
    retries_nxt = retries_r;
    rtt_nxt     = rtt_r;
    kind_nxt    = swarq_pkg::KIND_NONE;
    seq_nxt     = 1'b0;
    if (cmd.norm) begin
      rtt_nxt = rtt_adapt;
    end
    if (cmd.apply) begin
      case (func_r)
        swarq_pkg::FUNC_START: begin
          rtt_nxt     = init_clamped;
          acked_nxt   = '0;
          failed_nxt  = 1'b0;
          retries_nxt = swarq_pkg::RETRY_RESET;
          sends_nxt   = 8'd1;
          if (block_count != '0) begin
            phase_nxt = PH_DATA;
            kind_nxt  = swarq_pkg::KIND_DATA;
          end else begin
            phase_nxt = PH_FINAL;
            kind_nxt  = swarq_pkg::KIND_FINAL;
          end
        end
        swarq_pkg::FUNC_ACK: begin
          if (phase_r == PH_DATA) begin
            if (matched) begin
              acked_nxt = acked_inc;
              sends_nxt = 8'd1;
              if (acked_inc < block_count) begin
                kind_nxt = swarq_pkg::KIND_DATA;
                seq_nxt  = acked_inc[0];
              end else begin
                phase_nxt   = PH_FINAL;
                retries_nxt = swarq_pkg::RETRY_RESET;
                kind_nxt    = swarq_pkg::KIND_FINAL;
              end
            end
          end else if (phase_r == PH_FINAL) begin
            phase_nxt  = PH_ENDED;
            failed_nxt = 1'b0;
          end
        end
        swarq_pkg::FUNC_EXPIRE: begin
          if (phase_r == PH_DATA) begin
            sends_nxt = sends_inc;
            kind_nxt  = swarq_pkg::KIND_DATA;
            seq_nxt   = acked_r[0];
          end else if (phase_r == PH_FINAL) begin
            if (retries_r != '0) begin
              retries_nxt = retries_r - 2'd1;
              sends_nxt   = sends_inc;
              kind_nxt    = swarq_pkg::KIND_FINAL;
            end else begin
              phase_nxt  = PH_ENDED;
              failed_nxt = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_r)
      PH_IDLE:  stat = swarq_pkg::STAT_IDLE;
      PH_ENDED: stat = failed_r ? swarq_pkg::STAT_FAILED : swarq_pkg::STAT_DONE;
      default:  stat = swarq_pkg::STAT_BUSY;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      failed_r    <= 1'b0;
      acked_r     <= '0;
      sends_r     <= '0;
      retries_r   <= swarq_pkg::RETRY_RESET;
      rtt_r       <= swarq_pkg::TMO_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      failed_r    <= failed_nxt;
      acked_r     <= acked_nxt;
      sends_r     <= sends_nxt;
      retries_r   <= retries_nxt;
      rtt_r       <= rtt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      ack_r  <= in_ack_bit;
      elap_r <= in_elapsed_us;
    end
    if (cmd.mul) begin
      rt_r <= 28'(resends) * 28'(rtt_r);
    end
    if (cmd.scale) begin
      x_r  <= 31'({rt_r, 2'b00}) + 31'({rt_r, 1'b0});
      e5_r <= 27'({elap_r, 2'b00}) + 27'(elap_r);
    end
    if (cmd.div) begin
      qf_r   <= qf_prod[62:34];
      wold_r <= w_full;
    end
    if (cmd.sub) begin
      m_r <= $signed({8'b0, elap_r}) - $signed({3'b0, qf_r}) - $signed({31'b0, round_up});
    end
    if (cmd.add) begin
      m2_r <= (m_r >= half_t) ? m_r + $signed({11'b0, wold_r}) : m_r;
    end
    if (cmd.mac) begin
      v_r <= $signed(seven_t) + m2_r + (m2_r <<< 1);
    end
    if (cmd.apply) begin
      kind_r <= kind_nxt;
      seq_r  <= seq_nxt;
    end
    if (cmd.wcalc) begin
      w_r <= (w_full > 21'(swarq_pkg::TMO_MAX)) ? swarq_pkg::TMO_MAX : w_full[19:0];
    end
    if (cmd.load) begin
      out_kind_r <= kind_r;
      out_seq_r  <= seq_r;
      out_load_r <= (kind_r != swarq_pkg::KIND_NONE) ? w_r : '0;
      out_stat_r <= stat;
      out_tmo_r  <= rtt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_send_kind      = out_kind_r;
  assign out_seq_bit        = out_seq_r;
  assign out_timer_load_us  = out_load_r;
  assign out_status         = out_stat_r;
  assign out_timeout_now_us = out_tmo_r;

endmodule

`default_nettype wire

[rtl/core/stop_and_wait_arq_sender.sv]
// Stop-and-wait sender with alternating sequence bit and adaptive timeout.
// Input channel (in_*): one event item per transfer (start, ack or timer
// expiry); result channel (out_*): exactly one result item per event, giving
// what to send, the sequence bit, the timer load, status and the timeout.
// Block count and initial timeout must be written through the APB port while
// idle; the block itself does not enforce this. A matching ack (one for the
// block in flight) runs the seven-step datapath timeout update (multiply, scale,
// divide, subtract, add, multiply-accumulate, normalise); other events skip it.
// The block takes no new event until the controller has stepped through capture,
// update, wait calc and output load for the last one.
// Reset: transfer idle, block count 0, initial timeout 1000 us, no result held.
// When the receiver stalls, the result register holds its item; the block
// still takes one more event, processes it, and holds in_stall high until the
// output register is free.
`default_nettype none

`include "stop_and_wait_arq_sender_defines.svh"

module stop_and_wait_arq_sender (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swarq_pkg::ADDR_W-1:0]  paddr,
  input  logic [swarq_pkg::DATA_W-1:0]  pwdata,
  output logic [swarq_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swarq_pkg::FUNC_W-1:0]  in_func,
  input  logic                          in_ack_bit,
  input  logic [swarq_pkg::ELAP_W-1:0]  in_elapsed_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swarq_pkg::KIND_W-1:0]  out_send_kind,
  output logic                          out_seq_bit,
  output logic [swarq_pkg::TMO_W-1:0]   out_timer_load_us,
  output logic [swarq_pkg::STAT_W-1:0]  out_status,
  output logic [swarq_pkg::TMO_W-1:0]   out_timeout_now_us
);

  logic [swarq_pkg::BLK_W-1:0] block_count;
  logic [swarq_pkg::TMO_W-1:0] init_timeout;
  swarq_pkg::cmd_t             cmd;
  swarq_pkg::sts_t             sts;

  swarq_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .block_count  (block_count),
    .init_timeout (init_timeout)
  );

  swarq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swarq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_ack_bit         (in_ack_bit),
    .in_elapsed_us      (in_elapsed_us),
    .block_count        (block_count),
    .init_timeout       (init_timeout),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_send_kind      (out_send_kind),
    .out_seq_bit        (out_seq_bit),
    .out_timer_load_us  (out_timer_load_us),
    .out_status         (out_status),
    .out_timeout_now_us (out_timeout_now_us)
  );

  `SWARQ_ASSERT_SAME(a_load_free, clk, rst_n, cmd.load, !out_valid || !out_stall, "result overwritten")
  `SWARQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "item taken twice")
  `SWARQ_ASSERT_SAME(a_tmo_nonzero, clk, rst_n, out_valid, out_timeout_now_us != '0, "zero timeout")
  `SWARQ_ASSERT_SAME(a_no_send_idle, clk, rst_n, out_valid && out_status != swarq_pkg::STAT_BUSY, out_send_kind == swarq_pkg::KIND_NONE, "send while not busy")

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;

  localparam logic [swarq_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam longint TMO_CAP = longint'(swarq_pkg::TMO_MAX);

  typedef enum logic [3:0] {
    XFER_IDLE  = 4'b0001,
    XFER_DATA  = 4'b0010,
    XFER_FINAL = 4'b0100,
    XFER_ENDED = 4'b1000
  } xfer_phase_t;

  typedef struct packed {
    logic [swarq_pkg::KIND_W-1:0] kind;
    logic                         seq;
    logic [swarq_pkg::TMO_W-1:0]  load;
    logic [swarq_pkg::STAT_W-1:0] status;
    logic [swarq_pkg::TMO_W-1:0]  tmo;
  } sender_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [swarq_pkg::ADDR_W-1:0] paddr = '0;
  logic [swarq_pkg::DATA_W-1:0] pwdata = '0;
  logic [swarq_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [swarq_pkg::FUNC_W-1:0] in_func = FUNC_NONE;
  logic in_ack_bit = 1'b0;
  logic [swarq_pkg::ELAP_W-1:0] in_elapsed_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [swarq_pkg::KIND_W-1:0] out_send_kind;
  logic out_seq_bit;
  logic [swarq_pkg::TMO_W-1:0] out_timer_load_us;
  logic [swarq_pkg::STAT_W-1:0] out_status;
  logic [swarq_pkg::TMO_W-1:0] out_timeout_now_us;

  stop_and_wait_arq_sender i_dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_ack_bit(in_ack_bit), .in_elapsed_us(in_elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_send_kind(out_send_kind),
    .out_seq_bit(out_seq_bit), .out_timer_load_us(out_timer_load_us),
    .out_status(out_status), .out_timeout_now_us(out_timeout_now_us)
  );

  // predictor state and its copy of the registers
  logic [swarq_pkg::BLK_W-1:0] block_count_reg = '0;
  logic [swarq_pkg::TMO_W-1:0] init_timeout_reg = swarq_pkg::TMO_RESET;
  xfer_phase_t xfer = XFER_IDLE;
  logic xfer_failed = 1'b0;
  logic [swarq_pkg::BLK_W-1:0] blocks_done = '0;
  logic [swarq_pkg::SEND_W-1:0] block_sends = '0;
  logic [swarq_pkg::RETRY_W-1:0] final_retries = swarq_pkg::RETRY_RESET;
  logic [swarq_pkg::TMO_W-1:0] rtt_us = swarq_pkg::TMO_RESET;

  sender_result_t expected_results[$];
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned receiver_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned n_events = 0;
  int unsigned n_results = 0;
  int unsigned n_starts = 0;
  int unsigned n_completed = 0;
  int unsigned n_failed = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic sender_result_t sender_next_result(logic [swarq_pkg::FUNC_W-1:0] f,
                                                        logic a,
                                                        logic [swarq_pkg::ELAP_W-1:0] e);
    sender_result_t r;
    longint t, resends, m, w;
    r = '0;
    r.kind = swarq_pkg::KIND_NONE;
    case (f)
      swarq_pkg::FUNC_START: begin
        rtt_us = (init_timeout_reg == '0) ? swarq_pkg::TMO_W'(1) : init_timeout_reg;
        blocks_done = '0;
        xfer_failed = 1'b0;
        final_retries = swarq_pkg::RETRY_RESET;
        n_starts++;
        if (block_count_reg != '0) begin
          xfer = XFER_DATA;
          block_sends = swarq_pkg::SEND_W'(1);
          r.kind = swarq_pkg::KIND_DATA;
        end else begin
          xfer = XFER_FINAL;
          final_retries = swarq_pkg::RETRY_RESET;
          block_sends = swarq_pkg::SEND_W'(1);
          r.kind = swarq_pkg::KIND_FINAL;
        end
      end
      swarq_pkg::FUNC_ACK: begin
        if (xfer == XFER_DATA && a == blocks_done[0]) begin
          t = longint'(rtt_us);
          resends = (block_sends != '0) ? longint'(block_sends) - 1 : 0;
          m = (5 * longint'(e) - 6 * resends * t) / 5;
          if (m >= t / 2) m = m + (6 * t) / 5;
          m = (7 * t + 3 * m) / 10;
          rtt_us = (m < 1) ? swarq_pkg::TMO_W'(1) :
                   (m > TMO_CAP) ? swarq_pkg::TMO_MAX : swarq_pkg::TMO_W'(m);
          blocks_done = blocks_done + 1'b1;
          if (blocks_done < block_count_reg) begin
            block_sends = swarq_pkg::SEND_W'(1);
            r.kind = swarq_pkg::KIND_DATA;
            r.seq = blocks_done[0];
          end else begin
            xfer = XFER_FINAL;
            final_retries = swarq_pkg::RETRY_RESET;
            block_sends = swarq_pkg::SEND_W'(1);
            r.kind = swarq_pkg::KIND_FINAL;
          end
        end else if (xfer == XFER_FINAL) begin
          xfer = XFER_ENDED;
          xfer_failed = 1'b0;
          n_completed++;
        end
      end
      swarq_pkg::FUNC_EXPIRE: begin
        if (xfer == XFER_DATA) begin
          if (block_sends < swarq_pkg::SEND_MAX) block_sends = block_sends + 1'b1;
          r.kind = swarq_pkg::KIND_DATA;
          r.seq = blocks_done[0];
        end else if (xfer == XFER_FINAL) begin
          if (final_retries != '0) begin
            final_retries = final_retries - 1'b1;
            if (block_sends < swarq_pkg::SEND_MAX) block_sends = block_sends + 1'b1;
            r.kind = swarq_pkg::KIND_FINAL;
          end else begin
            xfer = XFER_ENDED;
            xfer_failed = 1'b1;
            n_failed++;
          end
        end
      end
      default: ;
    endcase
    if (r.kind != swarq_pkg::KIND_NONE) begin
      w = (longint'(rtt_us) * 6) / 5;
      r.load = (w > TMO_CAP) ? swarq_pkg::TMO_MAX : swarq_pkg::TMO_W'(w);
    end
    case (xfer)
      XFER_IDLE: r.status = swarq_pkg::STAT_IDLE;
      XFER_ENDED: r.status = xfer_failed ? swarq_pkg::STAT_FAILED : swarq_pkg::STAT_DONE;
      default: r.status = swarq_pkg::STAT_BUSY;
    endcase
    r.tmo = rtt_us;
    return r;
  endfunction

  task automatic send_event(input logic [swarq_pkg::FUNC_W-1:0] f, input logic a,
                            input logic [swarq_pkg::ELAP_W-1:0] e);
    in_valid <= 1'b1;
    in_func <= f;
    in_ack_bit <= a;
    in_elapsed_us <= e;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(sender_next_result(f, a, e));
    n_events++;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
  endtask

  task automatic pause_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic drain_results();
    pause_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [swarq_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= swarq_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == swarq_pkg::REG_BLOCK_COUNT) block_count_reg = value[swarq_pkg::BLK_W-1:0];
    else init_timeout_reg = value[swarq_pkg::TMO_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_random_event();
    int unsigned pick, span;
    logic [swarq_pkg::ELAP_W-1:0] e;
    pick = $urandom_range(99);
    span = (int'(block_sends) + 1) * int'(rtt_us);
    if (span > 32'hFFFFFF) span = 32'hFFFFFF;
    case ($urandom_range(2))
      0: e = swarq_pkg::ELAP_W'($urandom_range(span));
      1: e = swarq_pkg::ELAP_W'($urandom_range(int'(rtt_us)));
      default: e = swarq_pkg::ELAP_W'($urandom());
    endcase
    case (xfer)
      XFER_DATA: begin
        if (pick < 50) send_event(swarq_pkg::FUNC_ACK, blocks_done[0], e);
        else if (pick < 78) send_event(swarq_pkg::FUNC_EXPIRE, 1'($urandom()), e);
        else if (pick < 88) send_event(swarq_pkg::FUNC_ACK, ~blocks_done[0], e);
        else if (pick < 92) send_event(swarq_pkg::FUNC_START, 1'($urandom()), e);
        else send_event(swarq_pkg::FUNC_W'($urandom()), 1'($urandom()), e);
      end
      XFER_FINAL: begin
        if (pick < 45) send_event(swarq_pkg::FUNC_EXPIRE, 1'($urandom()), e);
        else if (pick < 75) send_event(swarq_pkg::FUNC_ACK, 1'($urandom()), e);
        else send_event(swarq_pkg::FUNC_W'($urandom()), 1'($urandom()), e);
      end
      default: begin
        if (pick < 85) send_event(swarq_pkg::FUNC_START, 1'($urandom()), e);
        else send_event(swarq_pkg::FUNC_W'($urandom()), 1'($urandom()), e);
      end
    endcase
  endtask

  task automatic test_idle_events();
    send_event(swarq_pkg::FUNC_ACK, 1'b1, 24'hFFFFFF);
    send_event(swarq_pkg::FUNC_EXPIRE, 1'b0, 24'h000000);
    send_event(FUNC_NONE, 1'b1, 24'hAAAAAA);
  endtask

  task automatic test_final_packet();
    send_event(swarq_pkg::FUNC_START, 1'b0, 24'd0);
    repeat (3) send_event(swarq_pkg::FUNC_EXPIRE, 1'b0, 24'd0);
    send_event(swarq_pkg::FUNC_EXPIRE, 1'b1, 24'd5);
    send_event(swarq_pkg::FUNC_ACK, 1'b0, 24'd100);
    send_event(swarq_pkg::FUNC_START, 1'b1, 24'd0);
    send_event(swarq_pkg::FUNC_ACK, 1'b1, 24'h555555);
  endtask

  task automatic test_data_blocks();
    drain_results();
    cfg_write(swarq_pkg::REG_BLOCK_COUNT, 32'd2);
    cfg_write(swarq_pkg::REG_INIT_TIMEOUT, 32'd0);
    send_event(swarq_pkg::FUNC_START, 1'b0, 24'd0);
    send_event(swarq_pkg::FUNC_ACK, 1'b1, 24'd10);
    send_event(swarq_pkg::FUNC_EXPIRE, 1'b0, 24'd0);
    send_event(swarq_pkg::FUNC_ACK, 1'b0, 24'hFFFFFF);
    send_event(swarq_pkg::FUNC_EXPIRE, 1'b0, 24'd0);
    send_event(swarq_pkg::FUNC_ACK, 1'b1, 24'd0);
    send_event(swarq_pkg::FUNC_ACK, 1'b0, 24'd7);
    send_event(swarq_pkg::FUNC_START, 1'b0, 24'd0);
    send_event(swarq_pkg::FUNC_START, 1'b1, 24'd3);
  endtask

  task automatic test_large_config();
    drain_results();
    cfg_write(swarq_pkg::REG_BLOCK_COUNT, 32'd65535);
    cfg_write(swarq_pkg::REG_INIT_TIMEOUT, 32'hFFFFF);
    send_event(swarq_pkg::FUNC_START, 1'b0, 24'd0);
    send_event(swarq_pkg::FUNC_ACK, 1'b0, 24'd0);
    send_event(swarq_pkg::FUNC_EXPIRE, 1'b1, 24'hFFFFFF);
  endtask

  task automatic test_random_transfers(input logic [swarq_pkg::BLK_W-1:0] blocks,
                                       input logic [swarq_pkg::TMO_W-1:0] tmo,
                                       input int unsigned count);
    drain_results();
    cfg_write(swarq_pkg::REG_BLOCK_COUNT, swarq_pkg::DATA_W'(blocks));
    cfg_write(swarq_pkg::REG_INIT_TIMEOUT, swarq_pkg::DATA_W'(tmo));
    repeat (count) begin
      if ($urandom_range(99) == 0) pause_for_results();
      send_random_event();
    end
  endtask

  task automatic test_backpressure();
    int unsigned saved_gap;
    drain_results();
    cfg_write(swarq_pkg::REG_BLOCK_COUNT, 32'd40);
    cfg_write(swarq_pkg::REG_INIT_TIMEOUT, 32'd500);
    saved_gap = send_gap_pct;
    send_gap_pct = 0;
    receiver_hold = 300;
    send_event(swarq_pkg::FUNC_START, 1'b0, 24'd0);
    repeat (8) begin
      send_event(swarq_pkg::FUNC_EXPIRE, 1'b0, 24'd0);
      send_event(swarq_pkg::FUNC_ACK, blocks_done[0],
                 swarq_pkg::ELAP_W'($urandom_range(2000)));
    end
    send_gap_pct = saved_gap;
  endtask

  always @(posedge clk) begin
    if (receiver_hold != 0) begin
      out_stall <= 1'b1;
      receiver_hold = receiver_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    sender_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_send_kind, out_seq_bit, out_timer_load_us, out_status, out_timeout_now_us};
      n_results++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d seq=%0d load=%0d status=%0d timeout=%0d",
                   got.kind, got.seq, got.load, got.status, got.tmo);
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.seq !== want.seq || got.load !== want.load ||
            got.status !== want.status || got.tmo !== want.tmo) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d expected: kind=%0d seq=%0d load=%0d status=%0d timeout=%0d",
                     n_results, want.kind, want.seq, want.load, want.status, want.tmo);
            $display("result %0d actual:   kind=%0d seq=%0d load=%0d status=%0d timeout=%0d",
                     n_results, got.kind, got.seq, got.load, got.status, got.tmo);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    send_gap_pct = 19;
    recv_stall_pct = 67;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_events();
    test_final_packet();
    test_data_blocks();
    test_large_config();
    test_random_transfers(16'd5, 20'd1000, 300);
    send_gap_pct = 67;
    recv_stall_pct = 19;
    test_random_transfers(16'd1, 20'd999999, 300);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_random_transfers(swarq_pkg::BLK_W'($urandom_range(2, 12)),
                          swarq_pkg::TMO_W'($urandom_range(1, 1048575)), 250);
    test_backpressure();
    test_random_transfers(16'd0, 20'd1, 100);
    test_random_transfers(swarq_pkg::BLK_W'($urandom()), swarq_pkg::TMO_W'($urandom()), 200);
    drain_results();
    $display("Ran %0d events through %0d transfers: %0d completed, %0d failed.",
             n_events, n_starts, n_completed, n_failed);
    $display("Checked %0d results, %0d mismatches.", n_results, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+rtl/core
rtl/core/swarq_pkg.sv
rtl/core/swarq_regs.sv
rtl/core/swarq_ctrl.sv
rtl/core/swarq_dp.sv
rtl/core/stop_and_wait_arq_sender.sv
tb/testbench.sv
